// File: hw/rtl/tps_pkg.sv
package tps_pkg;

  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int MAX_TILES_DEF   = 4096;

  localparam int COORD_W = 6;
  localparam int TPR_W   = 7;
  localparam int ENTRY_W = 14;
  localparam int SUM_W   = 13;
  localparam int SUM_MAX = 63 * 127 + 63;
  localparam int RK_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_PROMOTE = 3'd1,
    OP_UNLOCK  = 3'd2,
    OP_TAKE    = 3'd3,
    OP_FLUSH   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    K_DONE   = 3'd0,
    K_TILE   = 3'd1,
    K_UNLOCK = 3'd2,
    K_DEAD   = 3'd3,
    K_EMPTY  = 3'd4
  } job_kind_t;

  typedef enum logic [1:0] {
    E_TILE   = 2'd0,
    E_UNLOCK = 2'd1,
    E_DEAD   = 2'd2
  } entry_kind_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_HIGH = 2'd1,
    ST_LOW  = 2'd2
  } tile_st_t;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_CNT  = 2'd1,
    RD_LAST = 2'd2
  } rd_mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TPR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTEN  = 3'd5;

  // Number of compare-subtract steps that fold the status index into the map.
  function automatic int red_steps(input int max_tiles);
    int s;
    s = 0;
    for (int k = 0; k < 24; k++) begin
      if ((longint'(max_tiles) << s) <= longint'(SUM_MAX)) s = s + 1;
    end
    return s;
  endfunction

  typedef struct packed {
    logic        ld_in;
    logic        mul;
    logic        red;
    logic        st_wr;
    tile_st_t    st_wval;
    logic        st_sweep;
    logic        q_sel;
    logic        q_push;
    logic        push_unlock;
    rd_mode_t    q_rd;
    logic        q_pop;
    logic        q_dec;
    logic        q_wr_cnt;
    logic        wr_kill;
    logic        ld_take;
    logic        cnt_clr;
    logic        cnt_inc;
    logic        out_ld;
    job_kind_t   out_kind;
    logic        out_nq;
    logic        out_full;
  } tps_cmd_t;

  typedef struct packed {
    logic        out_free;
    logic        red_done;
    tile_st_t    st_rdata;
    op_t         op;
    logic        in_view;
    logic        out_en;
    logic        hi_empty;
    logic        lo_empty;
    logic        hi_full;
    logic        lo_full;
    logic        cnt_eq_hcount;
    logic        cnt_eq_lcount;
    logic        cnt_zero;
    logic        cnt_lo_last;
    logic        match;
    entry_kind_t front_kind;
    logic        map_last;
  } tps_status_t;

endpackage

// File: hw/rtl/tps_if.sv
interface tps_in_if import tps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [COORD_W-1:0] tile_x;
  logic [COORD_W-1:0] tile_y;
  modport source (output valid, opcode, tile_x, tile_y, input ready);
  modport sink (input valid, opcode, tile_x, tile_y, output ready);
endinterface

interface tps_out_if import tps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         job_kind;
  logic [COORD_W-1:0] job_tile_x;
  logic [COORD_W-1:0] job_tile_y;
  logic               newly_queued;
  logic               queue_full;
  modport source (output valid, job_kind, job_tile_x, job_tile_y, newly_queued, queue_full,
                  input ready);
  modport sink (input valid, job_kind, job_tile_x, job_tile_y, newly_queued, queue_full,
                output ready);
endinterface

interface tps_cfg_if import tps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/tps_ram.sv
module tps_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/tps_datapath.sv
module tps_datapath import tps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_TILES   = MAX_TILES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tps_cmd_t    cmd,
  output tps_status_t sts,
  tps_in_if.sink      in_ch,
  tps_out_if.source   out_ch,
  tps_cfg_if.sink     cfg_ch
);
  localparam int QA_W      = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int TIDX_W    = $clog2(MAX_TILES);
  localparam int CNT_W     = (CW > TIDX_W) ? CW : TIDX_W;
  localparam int RED_STEPS = red_steps(MAX_TILES);

  // Configuration registers
  logic [TPR_W-1:0]   tpr_r;
  logic [COORD_W-1:0] left_r, top_r, right_r, bottom_r;
  logic               outen_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpr_r    <= TPR_W'(1);
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '1;
      bottom_r <= '1;
      outen_r  <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TPR:    tpr_r    <= cfg_ch.data;
        CFG_LEFT:   left_r   <= cfg_ch.data[COORD_W-1:0];
        CFG_TOP:    top_r    <= cfg_ch.data[COORD_W-1:0];
        CFG_RIGHT:  right_r  <= cfg_ch.data[COORD_W-1:0];
        CFG_BOTTOM: bottom_r <= cfg_ch.data[COORD_W-1:0];
        CFG_OUTEN:  outen_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Item registers and status index
  op_t                op_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [SUM_W-1:0]   sum_r;
  logic [RK_W-1:0]    rk_r;
  logic [31:0]        red_cmp;
  logic [TIDX_W-1:0]  idx;
  logic [ENTRY_W-1:0] tile_entry;

  assign red_cmp    = 32'(MAX_TILES) << (rk_r - RK_W'(1));
  assign idx        = TIDX_W'(sum_r);
  assign tile_entry = {E_TILE, y_r, x_r};

  logic [ENTRY_W-1:0] q_rdata [2];
  logic [ENTRY_W-1:0] sel_rdata;
  assign sel_rdata = cmd.q_sel ? q_rdata[1] : q_rdata[0];

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r <= op_t'(in_ch.opcode);
      x_r  <= in_ch.tile_x;
      y_r  <= in_ch.tile_y;
    end else if (cmd.ld_take) begin
      x_r <= sel_rdata[COORD_W-1:0];
      y_r <= sel_rdata[2*COORD_W-1:COORD_W];
    end
    if (cmd.mul) begin
      sum_r <= SUM_W'(y_r * tpr_r) + SUM_W'(x_r);
      rk_r  <= RK_W'(RED_STEPS);
    end else if (cmd.red) begin
      if (32'(sum_r) >= red_cmp) sum_r <= SUM_W'(32'(sum_r) - red_cmp);
      rk_r <= rk_r - RK_W'(1);
    end
  end

  // Shared counter for search, flush and map sweeps
  logic [CNT_W-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.cnt_clr) cnt_r <= '0;
    else if (cmd.cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
  end

  // Status map
  logic [1:0]        st_rdata;
  logic [TIDX_W-1:0] st_waddr;
  assign st_waddr = cmd.st_sweep ? TIDX_W'(cnt_r) : idx;

  tps_ram #(.W(2), .D(MAX_TILES)) u_map (
    .clk(clk), .we(cmd.st_wr), .waddr(st_waddr), .wdata(cmd.st_wval),
    .raddr(idx), .rdata(st_rdata)
  );

  function automatic logic [QA_W-1:0] qpos(input logic [QA_W-1:0] h,
                                           input logic [QA_W-1:0] off);
    logic [QA_W:0] s;
    s = {1'b0, h} + {1'b0, off};
    if (s >= (QA_W+1)'(QUEUE_DEPTH)) s = s - (QA_W+1)'(QUEUE_DEPTH);
    return s[QA_W-1:0];
  endfunction

  // Queues: index 0 is high, index 1 is low
  logic [QA_W-1:0] head_r  [2];
  logic [CW-1:0]   count_r [2];

  for (genvar g = 0; g < 2; g++) begin : g_q
    logic               act, we;
    logic [QA_W-1:0]    waddr, raddr;
    logic [ENTRY_W-1:0] wdata;

    assign act = (cmd.q_sel == 1'(g));
    assign we  = act && (cmd.q_push || cmd.q_wr_cnt);

    always_comb begin
      waddr = cmd.q_push ? qpos(head_r[g], QA_W'(count_r[g])) : qpos(head_r[g], QA_W'(cnt_r));
      if (cmd.q_push) wdata = cmd.push_unlock ? {E_UNLOCK, {2*COORD_W{1'b0}}} : tile_entry;
      else if (cmd.wr_kill) wdata = {E_DEAD, {2*COORD_W{1'b0}}};
      else wdata = q_rdata[g];
      case (cmd.q_rd)
        RD_CNT:  raddr = qpos(head_r[g], QA_W'(cnt_r));
        RD_LAST: raddr = qpos(head_r[g], QA_W'(count_r[g] - CW'(1)));
        default: raddr = head_r[g];
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        head_r[g]  <= '0;
        count_r[g] <= '0;
      end else if (act) begin
        if (cmd.q_push) count_r[g] <= count_r[g] + CW'(1);
        else if (cmd.q_dec) count_r[g] <= count_r[g] - CW'(1);
        else if (cmd.q_pop) begin
          count_r[g] <= count_r[g] - CW'(1);
          head_r[g]  <= (head_r[g] == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r[g] + QA_W'(1);
        end
      end
    end

    tps_ram #(.W(ENTRY_W), .D(QUEUE_DEPTH)) u_q (
      .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(q_rdata[g])
    );
  end

  // Result register
  logic                out_valid_r;
  job_kind_t           kind_r;
  logic [COORD_W-1:0]  jx_r, jy_r;
  logic                nq_r, full_r;
  logic                out_take;
  assign out_take = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_ld) out_valid_r <= 1'b1;
    else if (out_take) out_valid_r <= 1'b0;
    if (cmd.out_ld) begin
      kind_r <= cmd.out_kind;
      jx_r   <= (cmd.out_kind == K_TILE) ? x_r : '0;
      jy_r   <= (cmd.out_kind == K_TILE) ? y_r : '0;
      nq_r   <= cmd.out_nq;
      full_r <= cmd.out_full;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.job_kind     = kind_r;
  assign out_ch.job_tile_x   = jx_r;
  assign out_ch.job_tile_y   = jy_r;
  assign out_ch.newly_queued = nq_r;
  assign out_ch.queue_full   = full_r;

  // Status back to the controller
  always_comb begin
    sts.out_free      = !out_valid_r || out_ch.ready;
    sts.red_done      = (rk_r == '0);
    sts.st_rdata      = tile_st_t'(st_rdata);
    sts.op            = op_r;
    sts.in_view       = (x_r >= left_r) && (x_r <= right_r) && (y_r >= top_r) &&
                        (y_r <= bottom_r);
    sts.out_en        = outen_r;
    sts.hi_empty      = (count_r[0] == '0);
    sts.lo_empty      = (count_r[1] == '0);
    sts.hi_full       = (count_r[0] == CW'(QUEUE_DEPTH));
    sts.lo_full       = (count_r[1] == CW'(QUEUE_DEPTH));
    sts.cnt_eq_hcount = (cnt_r == CNT_W'(count_r[0]));
    sts.cnt_eq_lcount = (cnt_r == CNT_W'(count_r[1]));
    sts.cnt_zero      = (cnt_r == '0);
    sts.cnt_lo_last   = (cnt_r == CNT_W'(count_r[1] - CW'(1)));
    sts.match         = (q_rdata[1] == tile_entry);
    sts.front_kind    = entry_kind_t'(sel_rdata[ENTRY_W-1:2*COORD_W]);
    sts.map_last      = (cnt_r == CNT_W'(MAX_TILES - 1));
  end

`ifndef NO_ASSERTIONS
  a_hi_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[0] <= CW'(QUEUE_DEPTH)) else $error("high queue count overflow");
  a_lo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[1] <= CW'(QUEUE_DEPTH)) else $error("low queue count overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_push |-> (cmd.q_sel ? !sts.lo_full : !sts.hi_full))
    else $error("push into a full queue");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free) else $error("result register overwritten");
`endif
endmodule

// File: hw/rtl/tps_ctrl.sv
module tps_ctrl import tps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tps_status_t sts,
  output tps_cmd_t    cmd
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MUL, S_RED, S_STW, S_TKW, S_SRD, S_SCMP, S_MVW, S_FL, S_MCLR
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;
  logic   clr_r, clr_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;

  always_comb begin
    cmd       = '0;
    cmd.q_sel = sel_r;
    state_nxt = state_r;
    sel_nxt   = sel_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      // Sweep the status map to none after reset
      S_INIT: begin
        cmd.st_wr    = 1'b1;
        cmd.st_sweep = 1'b1;
        cmd.st_wval  = ST_NONE;
        cmd.cnt_inc  = 1'b1;
        if (sts.map_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.ld_in = 1'b1;
          clr_nxt   = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RED;
      end
      // Fold the index; a dequeued tile clears its map entry here
      S_RED: begin
        if (!sts.red_done) cmd.red = 1'b1;
        else if (clr_r) begin
          cmd.st_wr    = 1'b1;
          cmd.st_wval  = ST_NONE;
          cmd.out_ld   = 1'b1;
          cmd.out_kind = K_TILE;
          state_nxt    = S_IDLE;
        end else state_nxt = S_STW;
      end
      S_STW: begin
        cmd.out_kind = K_DONE;
        state_nxt    = S_IDLE;
        case (sts.op)
          OP_PUSH, OP_PROMOTE: begin
            cmd.out_ld = 1'b1;
            if (sts.in_view && sts.st_rdata == ST_LOW) begin
              cmd.q_sel = 1'b0;
              if (sts.hi_full) cmd.out_full = 1'b1;
              else begin
                cmd.q_push  = 1'b1;
                cmd.st_wr   = 1'b1;
                cmd.st_wval = ST_HIGH;
                cmd.cnt_clr = 1'b1;
                cmd.out_ld  = 1'b0;
                sel_nxt     = 1'b1;
                state_nxt   = S_SRD;
              end
            end else if (sts.op == OP_PUSH && sts.st_rdata == ST_NONE &&
                         (sts.in_view || sts.out_en)) begin
              cmd.q_sel = !sts.in_view;
              if (sts.in_view ? sts.hi_full : sts.lo_full) cmd.out_full = 1'b1;
              else begin
                cmd.q_push  = 1'b1;
                cmd.st_wr   = 1'b1;
                cmd.st_wval = sts.in_view ? ST_HIGH : ST_LOW;
                cmd.out_nq  = 1'b1;
              end
            end
          end
          OP_UNLOCK: begin
            cmd.out_ld = 1'b1;
            cmd.q_sel  = 1'b0;
            if (sts.hi_full) cmd.out_full = 1'b1;
            else begin
              cmd.q_push      = 1'b1;
              cmd.push_unlock = 1'b1;
              cmd.out_nq      = 1'b1;
            end
          end
          OP_TAKE: begin
            cmd.q_rd = RD_HEAD;
            if (!sts.hi_empty) begin
              sel_nxt   = 1'b0;
              state_nxt = S_TKW;
            end else if (!sts.lo_empty) begin
              sel_nxt   = 1'b1;
              state_nxt = S_TKW;
            end else begin
              cmd.out_ld   = 1'b1;
              cmd.out_kind = K_EMPTY;
            end
          end
          OP_FLUSH: begin
            cmd.cnt_clr = 1'b1;
            sel_nxt     = 1'b0;
            state_nxt   = S_FL;
          end
          default: cmd.out_ld = 1'b1;
        endcase
      end
      // Front entry is on the read port: pop it, and report it or start to clear its tile's map entry
      S_TKW: begin
        cmd.q_pop = 1'b1;
        state_nxt = S_IDLE;
        if (sts.front_kind == E_TILE) begin
          cmd.ld_take = 1'b1;
          clr_nxt     = 1'b1;
          state_nxt   = S_MUL;
        end else begin
          cmd.out_ld   = 1'b1;
          cmd.out_kind = (sts.front_kind == E_UNLOCK) ? K_UNLOCK : K_DEAD;
        end
      end
      // Search the low queue for the promoted tile
      S_SRD: begin
        cmd.q_rd = RD_CNT;
        if (sts.cnt_eq_lcount) begin
          cmd.out_ld   = 1'b1;
          cmd.out_kind = K_DONE;
          state_nxt    = S_IDLE;
        end else state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.q_rd = RD_LAST;
        if (sts.match) begin
          if (sts.cnt_zero || sts.cnt_lo_last) begin
            cmd.q_pop    = sts.cnt_zero;
            cmd.q_dec    = !sts.cnt_zero;
            cmd.out_ld   = 1'b1;
            cmd.out_kind = K_DONE;
            state_nxt    = S_IDLE;
          end else state_nxt = S_MVW;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      // Move the last entry into the hole
      S_MVW: begin
        cmd.q_wr_cnt = 1'b1;
        cmd.q_dec    = 1'b1;
        cmd.out_ld   = 1'b1;
        cmd.out_kind = K_DONE;
        state_nxt    = S_IDLE;
      end
      // Tombstone every queued entry, high then low
      S_FL: begin
        if (sel_r ? sts.cnt_eq_lcount : sts.cnt_eq_hcount) begin
          cmd.cnt_clr = 1'b1;
          sel_nxt     = 1'b1;
          if (sel_r) state_nxt = S_MCLR;
        end else begin
          cmd.q_wr_cnt = 1'b1;
          cmd.wr_kill  = 1'b1;
          cmd.cnt_inc  = 1'b1;
        end
      end
      S_MCLR: begin
        cmd.st_wr    = 1'b1;
        cmd.st_sweep = 1'b1;
        cmd.st_wval  = ST_NONE;
        cmd.cnt_inc  = 1'b1;
        if (sts.map_last) begin
          cmd.cnt_clr  = 1'b1;
          cmd.out_ld   = 1'b1;
          cmd.out_kind = K_DONE;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      sel_r   <= 1'b0;
      clr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      clr_r   <= clr_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL)) else $error("accept did not start work");
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> (state_r == S_IDLE)) else $error("result issued mid operation");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
`endif
endmodule

// File: hw/rtl/tile_priority_scheduler_top.sv
// Dirty-tile scheduler with a high and a low queue and a status map that
// suppresses duplicates. One item is worked at a time; each gives one result.
// After reset the block sweeps the whole status map before it accepts its
// first item. A push or unlock multiplies out the tile's map index, folds it
// with compare-subtract steps (one at the default sizes) and reads the map
// entry before it reports; a take-next of a tile job also recomputes the
// tile's map index to clear it, while a marker or tombstone is reported as it
// is popped. A promotion searches the low queue entry by entry and fills the
// hole of a match with the last entry. A flush walks both queues and then the
// whole map. The sequencer works each of these steps through the single read
// port of each queue and map memory.
module tile_priority_scheduler_top import tps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_TILES   = MAX_TILES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tps_in_if.sink    in_ch,
  tps_out_if.source out_ch,
  tps_cfg_if.sink   cfg_ch
);
  tps_cmd_t    cmd;
  tps_status_t sts;

  tps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  tps_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_TILES(MAX_TILES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );
endmodule

// File: test/tile_priority_scheduler_checker.sv
`timescale 1ns / 100ps

module tile_priority_scheduler_checker import tps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tps_in_if.sink     in_ch,
  tps_out_if.sink    out_ch,
  tps_cfg_if.sink    cfg_ch,
  output int         fail_count,
  output int         pending_jobs
);

  localparam int QD = QUEUE_DEPTH_DEF;
  localparam int MT = MAX_TILES_DEF;

  typedef struct packed {
    logic [2:0] job_kind;
    logic [5:0] job_tile_x;
    logic [5:0] job_tile_y;
    logic       newly_queued;
    logic       queue_full;
  } job_t;

  typedef struct {
    logic [ENTRY_W-1:0] slot [QD];
    int                 head;
    int                 count;
  } job_queue_t;

  tile_st_t   map_state [MT];
  job_queue_t hi_q, lo_q;
  int         tpr, v_left, v_top, v_right, v_bottom;
  bit         outside_en;
  job_t       expected_jobs[$];

  function automatic logic [ENTRY_W-1:0] pack_entry(entry_kind_t k, int x, int y);
    return {k, y[5:0], x[5:0]};
  endfunction

  function automatic bit enqueue(ref job_queue_t q, input logic [ENTRY_W-1:0] e);
    if (q.count >= QD) return 0;
    q.slot[(q.head + q.count) % QD] = e;
    q.count++;
    return 1;
  endfunction

  function automatic void drop_entry(ref job_queue_t q, input logic [ENTRY_W-1:0] e);
    int i;
    for (i = 0; i < q.count; i++)
      if (q.slot[(q.head + i) % QD] == e) break;
    if (i >= q.count) return;
    if (i == 0) begin
      q.head = (q.head + 1) % QD;
    end else if (i != q.count - 1) begin
      q.slot[(q.head + i) % QD] = q.slot[(q.head + q.count - 1) % QD];
    end
    q.count--;
  endfunction

  function automatic int map_index(int x, int y);
    return (y * tpr + x) % MT;
  endfunction

  function automatic void dequeue(ref job_queue_t q, ref job_t r);
    logic [ENTRY_W-1:0] e;
    e = q.slot[q.head];
    q.head = (q.head + 1) % QD;
    q.count--;
    case (entry_kind_t'(e[13:12]))
      E_TILE: begin
        map_state[map_index(e[5:0], e[11:6])] = ST_NONE;
        r.job_kind   = K_TILE;
        r.job_tile_x = e[5:0];
        r.job_tile_y = e[11:6];
      end
      E_UNLOCK: r.job_kind = K_UNLOCK;
      default:  r.job_kind = K_DEAD;
    endcase
  endfunction

  // Predict the single result of one accepted item.
  function automatic job_t schedule_item(logic [2:0] op, int x, int y);
    job_t r;
    int idx;
    bit vis;
    logic [ENTRY_W-1:0] e;
    r = '0;
    idx = map_index(x, y);
    vis = x >= v_left && x <= v_right && y >= v_top && y <= v_bottom;
    e = pack_entry(E_TILE, x, y);
    case (op)
      OP_PUSH: begin
        if (vis) begin
          if (map_state[idx] == ST_NONE) begin
            if (enqueue(hi_q, e)) begin
              map_state[idx] = ST_HIGH;
              r.newly_queued = 1;
            end else r.queue_full = 1;
          end else if (map_state[idx] == ST_LOW) begin
            if (enqueue(hi_q, e)) begin
              map_state[idx] = ST_HIGH;
              drop_entry(lo_q, e);
            end else r.queue_full = 1;
          end
        end else if (outside_en && map_state[idx] == ST_NONE) begin
          if (enqueue(lo_q, e)) begin
            map_state[idx] = ST_LOW;
            r.newly_queued = 1;
          end else r.queue_full = 1;
        end
      end
      OP_PROMOTE: begin
        if (vis && map_state[idx] == ST_LOW) begin
          if (enqueue(hi_q, e)) begin
            map_state[idx] = ST_HIGH;
            drop_entry(lo_q, e);
          end else r.queue_full = 1;
        end
      end
      OP_UNLOCK: begin
        if (enqueue(hi_q, pack_entry(E_UNLOCK, 0, 0))) r.newly_queued = 1;
        else r.queue_full = 1;
      end
      OP_TAKE: begin
        if (hi_q.count > 0) dequeue(hi_q, r);
        else if (lo_q.count > 0) dequeue(lo_q, r);
        else r.job_kind = K_EMPTY;
      end
      OP_FLUSH: begin
        for (int i = 0; i < hi_q.count; i++)
          hi_q.slot[(hi_q.head + i) % QD] = pack_entry(E_DEAD, 0, 0);
        for (int i = 0; i < lo_q.count; i++)
          lo_q.slot[(lo_q.head + i) % QD] = pack_entry(E_DEAD, 0, 0);
        foreach (map_state[i]) map_state[i] = ST_NONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    job_t got, want;
    if (!rst_n) begin
      foreach (map_state[i]) map_state[i] = ST_NONE;
      hi_q.head = 0; hi_q.count = 0;
      lo_q.head = 0; lo_q.count = 0;
      tpr = 1; v_left = 0; v_top = 0; v_right = 63; v_bottom = 63;
      outside_en = 1;
      expected_jobs.delete();
      fail_count = 0;
      pending_jobs = 0;
    end else begin
      // Apply register writes.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TPR:    tpr = cfg_ch.data;
          CFG_LEFT:   v_left = cfg_ch.data[5:0];
          CFG_TOP:    v_top = cfg_ch.data[5:0];
          CFG_RIGHT:  v_right = cfg_ch.data[5:0];
          CFG_BOTTOM: v_bottom = cfg_ch.data[5:0];
          CFG_OUTEN:  outside_en = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_jobs.push_back(schedule_item(in_ch.opcode, in_ch.tile_x, in_ch.tile_y));
      // Compare each result against the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.job_kind, out_ch.job_tile_x, out_ch.job_tile_y,
               out_ch.newly_queued, out_ch.queue_full};
        if (expected_jobs.size() == 0) begin
          $error("unexpected result item %p", got);
          fail_count++;
        end else begin
          want = expected_jobs.pop_front();
          if (got.job_kind !== want.job_kind) begin
            $error("job_kind exp %0d got %0d", want.job_kind, got.job_kind); fail_count++;
          end
          if (got.job_tile_x !== want.job_tile_x) begin
            $error("job_tile_x exp %0d got %0d", want.job_tile_x, got.job_tile_x);
            fail_count++;
          end
          if (got.job_tile_y !== want.job_tile_y) begin
            $error("job_tile_y exp %0d got %0d", want.job_tile_y, got.job_tile_y);
            fail_count++;
          end
          if (got.newly_queued !== want.newly_queued) begin
            $error("newly_queued exp %0d got %0d", want.newly_queued, got.newly_queued);
            fail_count++;
          end
          if (got.queue_full !== want.queue_full) begin
            $error("queue_full exp %0d got %0d", want.queue_full, got.queue_full);
            fail_count++;
          end
        end
      end
      pending_jobs = expected_jobs.size();
    end
  end

endmodule

// File: test/tile_priority_scheduler_top_tb.sv
`timescale 1ns / 100ps

module tile_priority_scheduler_top_tb import tps_pkg::*;;

  localparam int STALL_LIMIT = 60000;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending_jobs, idle_cycles, items_sent, tiles_taken, rx_wait;
  bit   long_hold;

  tps_in_if  in_ch ();
  tps_out_if out_ch ();
  tps_cfg_if cfg_ch ();

  tile_priority_scheduler_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  tile_priority_scheduler_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending_jobs(pending_jobs)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.opcode = '0; in_ch.tile_x = '0; in_ch.tile_y = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = '0; cfg_ch.data = '0;
  end

  // Receiver: drop ready for a random gap after each result taken, plus one long hold-off.
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ch.ready <= 0;
      rx_wait      <= 0;
    end else if (long_hold) begin
      out_ch.ready <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (out_ch.job_kind == K_TILE) tiles_taken++;
      gap = $urandom_range(0, 3);
      rx_wait      <= gap;
      out_ch.ready <= (gap == 0);
    end else if (rx_wait > 0) begin
      rx_wait      <= rx_wait - 1;
      out_ch.ready <= (rx_wait == 1);
    end else begin
      out_ch.ready <= 1;
    end
  end

  // Watchdog on cycles without any handshake on the input, result or register channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [2:0] op, logic [5:0] x, logic [5:0] y);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(posedge clk);
    in_ch.valid  <= 1;
    in_ch.opcode <= op;
    in_ch.tile_x <= x;
    in_ch.tile_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 0;
    items_sent++;
  endtask

  task automatic drain_results();
    while (pending_jobs != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  task automatic set_view(int tpr, int l, int t, int r, int b, int en);
    drain_results();
    write_reg(CFG_TPR, tpr);
    write_reg(CFG_LEFT, l);
    write_reg(CFG_TOP, t);
    write_reg(CFG_RIGHT, r);
    write_reg(CFG_BOTTOM, b);
    write_reg(CFG_OUTEN, en);
  endtask

  // Mostly pushes and takes on a small tile pool so duplicates and promotions occur.
  task automatic random_burst(int n);
    int roll;
    logic [2:0] op;
    logic [5:0] x, y;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) op = OP_PUSH;
      else if (roll < 60) op = OP_PROMOTE;
      else if (roll < 65) op = OP_UNLOCK;
      else if (roll < 95) op = OP_TAKE;
      else if (roll < 97) op = OP_FLUSH;
      else op = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 3) == 0) begin
        x = 6'($urandom); y = 6'($urandom);
      end else begin
        x = 6'($urandom_range(0, 11)); y = 6'($urandom_range(0, 11));
      end
      send_item(op, x, y);
    end
  endtask

  initial begin
    long_hold = 0;
    items_sent = 0;
    tiles_taken = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed: defaults, then extremes of the view and the row width.
    send_item(OP_TAKE, 0, 0);
    send_item(OP_PUSH, 0, 0);
    send_item(OP_PUSH, 63, 63);
    send_item(OP_PUSH, 0, 0);
    send_item(OP_UNLOCK, 0, 0);
    send_item(OP_TAKE, 0, 0);
    send_item(OP_FLUSH, 0, 0);
    send_item(OP_TAKE, 0, 0);
    send_item(OP_TAKE, 0, 0);
    send_item(OP_TAKE, 0, 0);
    send_item(3'd5, 63, 63);
    send_item(3'd7, 21, 42);
    set_view(64, 10, 10, 20, 20, 1);
    send_item(OP_PUSH, 5, 5);
    send_item(OP_PUSH, 6, 6);
    send_item(OP_PUSH, 7, 7);
    send_item(OP_PUSH, 5, 5);
    send_item(OP_PROMOTE, 5, 5);
    set_view(64, 0, 0, 63, 63, 1);
    send_item(OP_PUSH, 6, 6);
    send_item(OP_PROMOTE, 7, 7);
    send_item(OP_TAKE, 0, 0);
    send_item(OP_TAKE, 0, 0);
    send_item(OP_TAKE, 0, 0);
    // Empty view, outside disabled, then aliasing with a zero row width.
    set_view(0, 40, 40, 30, 30, 0);
    send_item(OP_PUSH, 1, 1);
    set_view(0, 40, 40, 30, 30, 1);
    send_item(OP_PUSH, 1, 2);
    send_item(OP_PUSH, 1, 9);
    set_view(0, 0, 0, 63, 63, 1);
    send_item(OP_PROMOTE, 1, 9);
    send_item(OP_FLUSH, 0, 0);

    // Random phases across several settings.
    set_view(1, 0, 0, 63, 63, 1);
    random_burst(100);
    set_view(12, 3, 2, 8, 9, 1);
    random_burst(110);

    // Let the input back up behind a stalled receiver.
    long_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      random_burst(60);
    join
    drain_results();

    set_view(127, 0, 0, 5, 5, 1);
    random_burst(100);
    set_view(7, 63, 63, 63, 63, 0);
    random_burst(100);
    set_view(64, 0, 0, 0, 0, 1);
    random_burst(100);
    drain_results();
    // Fill the high queue past its depth.
    set_view(64, 0, 0, 63, 63, 1);
    repeat (QUEUE_DEPTH_DEF + 4) send_item(OP_UNLOCK, 0, 0);
    send_item(OP_PUSH, 1, 1);
    send_item(OP_FLUSH, 0, 0);
    random_burst(120);
    drain_results();

    $display("Sent %0d items under a range of view settings; %0d tile jobs came back.",
             items_sent, tiles_taken);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
